FILE: rtl/core/rlc_pkg.sv
package rlc_pkg;

  // Fixed field widths of the route node and result beats.
  localparam int COORD_W = 16;
  localparam int IDX_W   = 8;
  localparam int ACC_W   = 48;

  // Largest route accepted; longer counts are clamped to this.
  localparam int MAX_CUSTOMERS = 255;
  localparam logic [IDX_W-1:0] COUNT_LIMIT =
    IDX_W'(MAX_CUSTOMERS < 255 ? MAX_CUSTOMERS : 255);

  // Saturation ceiling of the cost accumulator.
  localparam logic [ACC_W-1:0] ACC_MAX = '1;

  // Sequencer states of the cost datapath.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_LOAD,
    ST_ROOT,
    ST_SCALE,
    ST_ACC,
    ST_PUSH
  } rlc_state_t;

endpackage

FILE: rtl/core/route_latency_cost.sv
// Cumulative latency cost of a vehicle route. Each input beat is one route node;
// a beat with in_route_start high is the depot and opens a route of
// in_customer_count customers, and every later node adds its Euclidean distance
// to the previous node, weighted by the number of customers still to be served,
// to a saturating Q40.8 sum. Every input beat gives exactly one result beat
// carrying the running cost, the node index and a flag on the last customer.
// A customer node passes through ST_SQUARE, ST_LOAD, ST_ROOT, ST_SCALE, ST_ACC
// and ST_PUSH before the next node is accepted (coordinates limited to 16
// bits); ST_ROOT lasts until the square-root unit, which produces one root
// bit per cycle, is done. A depot, or a node arriving after the route is
// complete, goes straight to ST_PUSH. The next node is accepted while an earlier
// result still waits on the output register.
module route_latency_cost #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [rlc_pkg::COORD_W-1:0]  in_coord_x,
  input  logic [rlc_pkg::COORD_W-1:0]  in_coord_y,
  input  logic                         in_route_start,
  input  logic [rlc_pkg::IDX_W-1:0]    in_customer_count,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [rlc_pkg::ACC_W-1:0]    out_cumulative_cost,
  output logic [rlc_pkg::IDX_W-1:0]    out_node_index,
  output logic                         out_route_done
);

  import rlc_pkg::*;

  // Coordinates wider than the port are never seen.
  localparam int CW      = (COORD_BITS < COORD_W) ? COORD_BITS : COORD_W;
  localparam int PAIRS   = CW + 1;
  localparam int ROOT_W  = PAIRS + FRAC_BITS;
  localparam int SQ_W    = 2 * CW;
  localparam int TERM_W  = ROOT_W + IDX_W;
  localparam int SUM_W   = (TERM_W > ACC_W) ? TERM_W + 1 : ACC_W + 1;

  rlc_state_t         state_r, state_nxt;
  logic [CW-1:0]      px_r, px_nxt, py_r, py_nxt;
  logic [IDX_W-1:0]   pos_r, pos_nxt, size_r, size_nxt;
  logic [ACC_W-1:0]   acc_r, acc_nxt;
  logic [CW-1:0]      dx_r, dx_nxt, dy_r, dy_nxt;
  logic [SQ_W-1:0]    sqx_r, sqx_nxt, sqy_r, sqy_nxt;
  logic [IDX_W-1:0]   weight_r, weight_nxt;
  logic [TERM_W-1:0]  term_r, term_nxt;
  logic [ACC_W-1:0]   res_cost_r, res_cost_nxt;
  logic [IDX_W-1:0]   res_idx_r, res_idx_nxt;
  logic               res_done_r, res_done_nxt;
  logic [ACC_W-1:0]   out_cost_r, out_cost_nxt;
  logic [IDX_W-1:0]   out_idx_r, out_idx_nxt;
  logic               out_done_r, out_done_nxt;
  logic               out_valid_r, out_valid_nxt;

  logic [CW-1:0]      x_in, y_in;
  logic [IDX_W-1:0]   count_cl;
  logic               accept;
  logic               out_free;
  logic               root_start;
  logic [2*PAIRS-1:0] radicand;
  logic               root_done;
  logic [ROOT_W-1:0]  root;
  logic [SUM_W-1:0]   sum;
  logic [ACC_W-1:0]   sum_sat;

  // Serial square-root unit.
  rlc_sqrt #(
    .RAD_PAIRS (PAIRS),
    .FRAC_BITS (FRAC_BITS)
  ) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (root_start),
    .radicand (radicand),
    .done     (root_done),
    .root     (root)
  );

  // Input decode and the handshake terms.
  always_comb begin
    x_in     = in_coord_x[CW-1:0];
    y_in     = in_coord_y[CW-1:0];
    count_cl = (in_customer_count > COUNT_LIMIT) ? COUNT_LIMIT : in_customer_count;
    accept   = in_valid && (state_r == ST_IDLE);
    out_free = !out_valid_r || !out_stall;
    radicand = (2*PAIRS)'(sqx_r) + (2*PAIRS)'(sqy_r);
    sum      = SUM_W'(acc_r) + SUM_W'(term_r);
    sum_sat  = (sum > SUM_W'(ACC_MAX)) ? ACC_MAX : sum[ACC_W-1:0];
  end

  // Sequencer: next state and the next values of every register.
  always_comb begin
    state_nxt     = state_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    pos_nxt       = pos_r;
    size_nxt      = size_r;
    acc_nxt       = acc_r;
    dx_nxt        = dx_r;
    dy_nxt        = dy_r;
    sqx_nxt       = sqx_r;
    sqy_nxt       = sqy_r;
    weight_nxt    = weight_r;
    term_nxt      = term_r;
    res_cost_nxt  = res_cost_r;
    res_idx_nxt   = res_idx_r;
    res_done_nxt  = res_done_r;
    out_cost_nxt  = out_cost_r;
    out_idx_nxt   = out_idx_r;
    out_done_nxt  = out_done_r;
    out_valid_nxt = out_valid_r && out_stall;
    root_start    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_route_start) begin
            // Depot: open a new route with zero cost.
            px_nxt       = x_in;
            py_nxt       = y_in;
            pos_nxt      = '0;
            size_nxt     = count_cl;
            acc_nxt      = '0;
            res_cost_nxt = '0;
            res_idx_nxt  = '0;
            res_done_nxt = (count_cl == '0);
            state_nxt    = ST_PUSH;
          end else if (pos_r >= size_r) begin
            // Route already complete, or none opened: report and change nothing.
            res_cost_nxt = acc_r;
            res_idx_nxt  = pos_r;
            res_done_nxt = 1'b0;
            state_nxt    = ST_PUSH;
          end else begin
            dx_nxt       = (x_in >= px_r) ? (x_in - px_r) : (px_r - x_in);
            dy_nxt       = (y_in >= py_r) ? (y_in - py_r) : (py_r - y_in);
            px_nxt       = x_in;
            py_nxt       = y_in;
            weight_nxt   = size_r - pos_r;
            pos_nxt      = pos_r + IDX_W'(1);
            res_idx_nxt  = pos_r + IDX_W'(1);
            res_done_nxt = ((pos_r + IDX_W'(1)) == size_r);
            state_nxt    = ST_SQUARE;
          end
        end
      end
      ST_SQUARE: begin
        sqx_nxt   = dx_r * dx_r;
        sqy_nxt   = dy_r * dy_r;
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        root_start = 1'b1;
        state_nxt  = ST_ROOT;
      end
      ST_ROOT: begin
        if (root_done) begin
          state_nxt = ST_SCALE;
        end
      end
      ST_SCALE: begin
        term_nxt  = TERM_W'(root) * TERM_W'(weight_r);
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        acc_nxt      = sum_sat;
        res_cost_nxt = sum_sat;
        state_nxt    = ST_PUSH;
      end
      ST_PUSH: begin
        // Hand the result to the output register once it is free.
        if (out_free) begin
          out_cost_nxt  = res_cost_r;
          out_idx_nxt   = res_idx_r;
          out_done_nxt  = res_done_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control and route state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      px_r        <= '0;
      py_r        <= '0;
      pos_r       <= '0;
      size_r      <= '0;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      px_r        <= px_nxt;
      py_r        <= py_nxt;
      pos_r       <= pos_nxt;
      size_r      <= size_nxt;
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath and result payload.
  always_ff @(posedge clk) begin
    dx_r       <= dx_nxt;
    dy_r       <= dy_nxt;
    sqx_r      <= sqx_nxt;
    sqy_r      <= sqy_nxt;
    weight_r   <= weight_nxt;
    term_r     <= term_nxt;
    res_cost_r <= res_cost_nxt;
    res_idx_r  <= res_idx_nxt;
    res_done_r <= res_done_nxt;
    out_cost_r <= out_cost_nxt;
    out_idx_r  <= out_idx_nxt;
    out_done_r <= out_done_nxt;
  end

  assign in_stall            = (state_r != ST_IDLE);
  assign out_valid           = out_valid_r;
  assign out_cumulative_cost = out_cost_r;
  assign out_node_index      = out_idx_r;
  assign out_route_done      = out_done_r;

endmodule

FILE: rtl/core/rlc_sqrt.sv
module rlc_sqrt #(
  parameter int RAD_PAIRS = 17,
  parameter int FRAC_BITS = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [2*RAD_PAIRS-1:0]           radicand,
  output logic                             done,
  output logic [RAD_PAIRS+FRAC_BITS-1:0]   root
);

  localparam int ROOT_W = RAD_PAIRS + FRAC_BITS;
  localparam int REM_W  = ROOT_W + 2;
  localparam int RAD_W  = 2 * RAD_PAIRS;
  localparam int CNT_W  = $clog2(ROOT_W + 1);

  logic [RAD_W-1:0]  rad_r,  rad_nxt;
  logic [REM_W-1:0]  rem_r,  rem_nxt;
  logic [ROOT_W-1:0] root_r, root_nxt;
  logic [CNT_W-1:0]  cnt_r,  cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;

  logic [1:0]        pair;
  logic [REM_W-1:0]  rem_sh;
  logic [REM_W-1:0]  trial;
  logic              fits;

  // One root bit per cycle: the radicand leaves its shift register two bits at a
  // time, most significant pair first, and zeros follow for the fraction bits.
  always_comb begin
    pair     = rad_r[RAD_W-1 -: 2];
    rem_sh   = {rem_r[REM_W-3:0], pair};
    trial    = {root_r, 2'b01};
    fits     = (rem_sh >= trial);
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rad_nxt  = radicand;
      rem_nxt  = '0;
      root_nxt = '0;
      cnt_nxt  = CNT_W'(ROOT_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rad_nxt  = {rad_r[RAD_W-3:0], 2'b00};
      rem_nxt  = fits ? (rem_sh - trial) : rem_sh;
      root_nxt = {root_r[ROOT_W-2:0], fits};
      cnt_nxt  = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Iteration control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // Radicand, partial remainder and partial root.
  always_ff @(posedge clk) begin
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign done = done_r;
  assign root = root_r;

endmodule
